[rtl/bpf_pkg.sv]
// Shared types, codes and defaults for the Bezier path flattener.
// No dependencies; every other file but bpf_queue.sv refers to it by scoped names.
package bpf_pkg;

  // Default parameter values.
  localparam int MAX_POINTS_DEF  = 63;
  localparam int COORD_WIDTH_DEF = 24;

  // Field widths fixed by the segment format.
  localparam int FUNC_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int JOB_KIND_W = 2;

  // Segment function codes.
  localparam logic [FUNC_W-1:0] FN_MOVE   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LINE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SQUAD  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_QUAD   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SCUBIC = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CUBIC  = 3'd5;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_QUAD_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUBIC_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN   = 2'd2;
  localparam logic [4:0] QUAD_MIN_RST  = 5'd5;
  localparam logic [4:0] CUBIC_MIN_RST = 5'd10;
  localparam logic [7:0] SEG_LEN_RST   = 8'd30;

  // Side magnitude limit and control polygon length limit.
  localparam logic [32:0] MAG_CAP = 33'h07FFFFFFF;
  localparam logic [24:0] LEN_CAP = 25'h1000000;

  // Kind of work handed from the front to the back.
  typedef enum logic [JOB_KIND_W-1:0] {
    JOB_LINE,
    JOB_QUAD,
    JOB_CUBIC
  } job_kind_t;

  // Back end sequencer states.
  typedef enum logic [4:0] {
    BK_IDLE,
    BK_SQ_DX,
    BK_SQ_DY,
    BK_SQRT,
    BK_CNT_A,
    BK_CNT_B,
    BK_CNT_C,
    BK_CNT_D,
    BK_SEARCH,
    BK_START,
    BK_WGT_A,
    BK_WGT_B,
    BK_MAC,
    BK_DIV_PREP,
    BK_DIV,
    BK_POINT,
    BK_END
  } back_state_t;

endpackage

[rtl/bpf_if.sv]
// Handshake channel interfaces: path segments in, polyline points out, register writes.
// Depends on bpf_pkg for defaults and field widths.
interface bpf_seg_if #(parameter int CW = bpf_pkg::COORD_WIDTH_DEF) ();
  logic                        valid;
  logic                        ready;
  logic [bpf_pkg::FUNC_W-1:0]  func;
  logic signed [CW-1:0]        end_x;
  logic signed [CW-1:0]        end_y;
  logic signed [CW-1:0]        ctrl1_x;
  logic signed [CW-1:0]        ctrl1_y;
  logic signed [CW-1:0]        ctrl2_x;
  logic signed [CW-1:0]        ctrl2_y;
  modport source (output valid, func, end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                  input ready);
  modport sink (input valid, func, end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                output ready);
endinterface

interface bpf_pt_if #(parameter int CW = bpf_pkg::COORD_WIDTH_DEF) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic                 last;
  modport source (output valid, point_x, point_y, last, input ready);
  modport sink (input valid, point_x, point_y, last, output ready);
endinterface

interface bpf_cfg_if ();
  logic                           valid;
  logic                           ready;
  logic [bpf_pkg::CFG_IDX_W-1:0]  index;
  logic [bpf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/bezier_path_flattener.sv]
// Bezier path flattener. Each segment request (move, line, smooth or plain
// quadratic, smooth or plain cubic) turns into polyline points, the last one
// flagged. A move or line goes from the back end's idle state straight to
// its end state, which pushes the one point. A curve first measures each
// control polygon side with a square root that resolves one bit per cycle,
// then forms the count terms and searches the point count one candidate at
// a time, then per inner point forms Bernstein weights, sums the products and
// rounds with a shift-subtract divider; output stalls hold each push. A
// two-entry queue lets new requests be taken while a curve is still being
// emitted, and the output is registered.
module bezier_path_flattener #(
  parameter int MAX_POINTS  = bpf_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = bpf_pkg::COORD_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  bpf_seg_if.sink  seg,
  bpf_pt_if.source pt,
  bpf_cfg_if.sink  cfg
);
  localparam int JW = bpf_pkg::JOB_KIND_W + 8 * COORD_WIDTH;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [JW-1:0] f_job, b_job;

  // Request intake and path state.
  bpf_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .seg(seg),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  // Decoupling queue.
  bpf_queue #(.W(JW)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_job),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_job)
  );

  // Curve evaluation and point output.
  bpf_back #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .cfg(cfg), .pt(pt)
  );

endmodule

[rtl/bpf_front.sv]
// Front end: accepts segment requests, keeps the current and reflected control
// point, and packs a job for the back end. Depends on bpf_pkg and bpf_seg_if.
module bpf_front #(
  parameter int COORD_WIDTH = bpf_pkg::COORD_WIDTH_DEF,
  localparam int JW = bpf_pkg::JOB_KIND_W + 8 * COORD_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  bpf_seg_if.sink       seg,
  output logic          job_valid,
  input  logic          job_ready,
  output logic [JW-1:0] job
);
  localparam int CW = COORD_WIDTH;

  logic signed [CW-1:0] cur_x, cur_y, refl_x, refl_y;
  logic signed [CW-1:0] b_x, b_y, c_x, c_y, p2_x, p2_y, src_x, src_y;
  logic                 is_line, is_quad, is_cubic, smooth;
  bpf_pkg::job_kind_t   kind;

  // Saturating reflection 2*e - c.
  function automatic logic signed [CW-1:0] reflect(input logic signed [CW-1:0] e,
                                                   input logic signed [CW-1:0] c);
    logic signed [CW+1:0] d;
    d = {e[CW-1], e, 1'b0} - {{2{c[CW-1]}}, c};
    if (d[CW+1:CW-1] != {3{d[CW+1]}}) begin
      reflect = d[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      reflect = d[CW-1:0];
    end
  endfunction

  // Classify the request and pick the control points.
  always_comb begin
    is_line  = (seg.func == bpf_pkg::FN_MOVE) || (seg.func == bpf_pkg::FN_LINE);
    is_quad  = (seg.func == bpf_pkg::FN_SQUAD) || (seg.func == bpf_pkg::FN_QUAD);
    is_cubic = (seg.func == bpf_pkg::FN_SCUBIC) || (seg.func == bpf_pkg::FN_CUBIC);
    smooth   = (seg.func == bpf_pkg::FN_SQUAD) || (seg.func == bpf_pkg::FN_SCUBIC);
    b_x  = smooth ? refl_x : seg.ctrl1_x;
    b_y  = smooth ? refl_y : seg.ctrl1_y;
    c_x  = (seg.func == bpf_pkg::FN_SCUBIC) ? seg.ctrl1_x : seg.ctrl2_x;
    c_y  = (seg.func == bpf_pkg::FN_SCUBIC) ? seg.ctrl1_y : seg.ctrl2_y;
    p2_x = is_quad ? seg.end_x : c_x;
    p2_y = is_quad ? seg.end_y : c_y;
    src_x = is_quad ? b_x : c_x;
    src_y = is_quad ? b_y : c_y;
    if (is_line) begin
      kind = bpf_pkg::JOB_LINE;
    end else if (is_quad) begin
      kind = bpf_pkg::JOB_QUAD;
    end else begin
      kind = bpf_pkg::JOB_CUBIC;
    end
  end

  // Unused function codes are accepted and dropped.
  assign seg.ready = job_ready;
  assign job_valid = seg.valid && (is_line || is_quad || is_cubic);
  assign job = {kind, cur_x, cur_y, b_x, b_y, p2_x, p2_y, seg.end_x, seg.end_y};

  // Path state advances with every queued segment.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x  <= '0;
      cur_y  <= '0;
      refl_x <= '0;
      refl_y <= '0;
    end else if (job_valid && job_ready) begin
      cur_x <= seg.end_x;
      cur_y <= seg.end_y;
      if (is_line) begin
        refl_x <= seg.end_x;
        refl_y <= seg.end_y;
      end else begin
        refl_x <= reflect(seg.end_x, src_x);
        refl_y <= reflect(seg.end_y, src_y);
      end
    end
  end

endmodule

[rtl/bpf_queue.sv]
// Two-entry job queue between the front and back ends.
// No dependencies beyond the data width parameter.
module bpf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  logic [W-1:0] mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

endmodule

[rtl/bpf_back.sv]
// Back end: measures the control polygon, picks the point count and emits the
// polyline through a registered output. Depends on bpf_pkg, bpf_cfg_if, bpf_pt_if.
module bpf_back #(
  parameter int MAX_POINTS  = bpf_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = bpf_pkg::COORD_WIDTH_DEF,
  localparam int JW = bpf_pkg::JOB_KIND_W + 8 * COORD_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  logic [JW-1:0] job,
  bpf_cfg_if.sink       cfg,
  bpf_pt_if.source      pt
);
  localparam int CW   = COORD_WIDTH;
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int UW   = 2 * NW;
  localparam int WW   = 3 * NW;
  localparam int NUMW = CW + WW + 1;
  localparam int TW   = NUMW + 2;
  localparam int AW   = TW;
  localparam int QW   = CW;
  localparam int DJW  = $clog2(QW);

  bpf_pkg::back_state_t state, state_next;
  bpf_pkg::job_kind_t   kind;

  logic [4:0] quad_min, cubic_min;
  logic [7:0] seg_len;

  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];
  logic [1:0]  side, last_side;
  logic [61:0] dsq;
  logic [63:0] sq_v, sq_r, sq_b, r_new, v_new;
  logic [4:0]  sq_bit;
  logic [24:0] len;
  logic [33:0] len_sum;
  logic [49:0] lsq;
  logic [15:0] ss;
  logic [9:0]  mm;
  logic [34:0] kc;
  logic [44:0] km;
  logic [51:0] target, kn2, kstep;
  logic [NW-1:0] n, idx, u;
  logic [UW-1:0] uu, ui, ii, nn;
  logic [WW-1:0] w [4];
  logic [WW-1:0] den, m_uui, m_uii;
  logic [1:0]  j, last_j;
  logic signed [NUMW-1:0] accx, accy, prx, pry;
  logic signed [TW-1:0]   tx, ty;
  logic [AW-1:0] ax, ay, dsh;
  logic          negx, negy;
  logic [QW-1:0] qx, qy;
  logic [DJW-1:0] dj;
  logic [7:0]  s_eff;
  logic [4:0]  m_sel;
  logic signed [CW:0] dxw, dyw;
  logic [CW:0]  magx, magy;
  logic [30:0]  m31x, m31y;
  logic        o_free, push, push_last;
  logic signed [CW-1:0] push_x, push_y;
  logic        o_valid, o_last;
  logic signed [CW-1:0] o_x, o_y;

  // Configuration registers.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_min  <= bpf_pkg::QUAD_MIN_RST;
      cubic_min <= bpf_pkg::CUBIC_MIN_RST;
      seg_len   <= bpf_pkg::SEG_LEN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bpf_pkg::REG_QUAD_MIN:  quad_min  <= cfg.data[4:0];
        bpf_pkg::REG_CUBIC_MIN: cubic_min <= cfg.data[4:0];
        bpf_pkg::REG_SEG_LEN:   seg_len   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Datapath helpers: side magnitudes, square-root step, weights, products.
  always_comb begin
    dxw  = {px[2'(side + 2'd1)][CW-1], px[2'(side + 2'd1)]} - {px[side][CW-1], px[side]};
    dyw  = {py[2'(side + 2'd1)][CW-1], py[2'(side + 2'd1)]} - {py[side][CW-1], py[side]};
    magx = dxw[CW] ? (CW+1)'(-dxw) : (CW+1)'(dxw);
    magy = dyw[CW] ? (CW+1)'(-dyw) : (CW+1)'(dyw);
    m31x = (33'(magx) > bpf_pkg::MAG_CAP) ? bpf_pkg::MAG_CAP[30:0] : 31'(magx);
    m31y = (33'(magy) > bpf_pkg::MAG_CAP) ? bpf_pkg::MAG_CAP[30:0] : 31'(magy);
    sq_b = 64'(1) << {sq_bit, 1'b0};
    if (sq_v >= sq_r + sq_b) begin
      v_new = sq_v - (sq_r + sq_b);
      r_new = (sq_r >> 1) + sq_b;
    end else begin
      v_new = sq_v;
      r_new = sq_r >> 1;
    end
    len_sum   = 34'(len) + 34'(r_new[32:0]);
    last_side = (kind == bpf_pkg::JOB_QUAD) ? 2'd1 : 2'd2;
    last_j    = (kind == bpf_pkg::JOB_QUAD) ? 2'd2 : 2'd3;
    s_eff     = (seg_len == 8'd0) ? 8'd1 : seg_len;
    m_sel     = (kind == bpf_pkg::JOB_QUAD) ? quad_min : cubic_min;
    u         = n - idx;
    m_uui     = WW'(uu) * WW'(idx);
    m_uii     = WW'(ii) * WW'(u);
    prx = NUMW'($signed({1'b0, w[j]})) * NUMW'(px[j]);
    pry = NUMW'($signed({1'b0, w[j]})) * NUMW'(py[j]);
    tx  = (TW'(accx) <<< 1) + TW'($signed({1'b0, den}));
    ty  = (TW'(accy) <<< 1) + TW'($signed({1'b0, den}));
    dsh = AW'({den, 1'b0}) << dj;
  end

  assign o_free = !o_valid || pt.ready;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpf_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and output pushes.
  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    push_x     = px[0];
    push_y     = py[0];
    unique case (state)
      bpf_pkg::BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = (bpf_pkg::job_kind_t'(job[JW-1 -: bpf_pkg::JOB_KIND_W])
                        == bpf_pkg::JOB_LINE) ? bpf_pkg::BK_END : bpf_pkg::BK_SQ_DX;
        end
      end
      bpf_pkg::BK_SQ_DX: state_next = bpf_pkg::BK_SQ_DY;
      bpf_pkg::BK_SQ_DY: state_next = bpf_pkg::BK_SQRT;
      bpf_pkg::BK_SQRT: begin
        if (sq_bit == 5'd0) begin
          state_next = (side == last_side) ? bpf_pkg::BK_CNT_A : bpf_pkg::BK_SQ_DX;
        end
      end
      bpf_pkg::BK_CNT_A: state_next = bpf_pkg::BK_CNT_B;
      bpf_pkg::BK_CNT_B: state_next = bpf_pkg::BK_CNT_C;
      bpf_pkg::BK_CNT_C: state_next = bpf_pkg::BK_CNT_D;
      bpf_pkg::BK_CNT_D: state_next = bpf_pkg::BK_SEARCH;
      bpf_pkg::BK_SEARCH: begin
        if (kn2 >= target || n == NW'(MAX_POINTS)) state_next = bpf_pkg::BK_START;
      end
      bpf_pkg::BK_START: begin
        if (o_free) begin
          push       = 1'b1;
          state_next = (n == NW'(1)) ? bpf_pkg::BK_END : bpf_pkg::BK_WGT_A;
        end
      end
      bpf_pkg::BK_WGT_A: state_next = bpf_pkg::BK_WGT_B;
      bpf_pkg::BK_WGT_B: state_next = bpf_pkg::BK_MAC;
      bpf_pkg::BK_MAC: begin
        if (j == last_j) state_next = bpf_pkg::BK_DIV_PREP;
      end
      bpf_pkg::BK_DIV_PREP: state_next = bpf_pkg::BK_DIV;
      bpf_pkg::BK_DIV: begin
        if (dj == DJW'(0)) state_next = bpf_pkg::BK_POINT;
      end
      bpf_pkg::BK_POINT: begin
        push_x = negx ? -$signed(qx) : $signed(qx);
        push_y = negy ? -$signed(qy) : $signed(qy);
        if (o_free) begin
          push       = 1'b1;
          state_next = (NW'(idx + NW'(1)) == n) ? bpf_pkg::BK_END : bpf_pkg::BK_WGT_A;
        end
      end
      bpf_pkg::BK_END: begin
        push_x    = px[3];
        push_y    = py[3];
        push_last = 1'b1;
        if (o_free) begin
          push       = 1'b1;
          state_next = bpf_pkg::BK_IDLE;
        end
      end
      default: state_next = bpf_pkg::BK_IDLE;
    endcase
  end

  // Working registers, advanced by the sequencer state.
  always_ff @(posedge clk) begin
    unique case (state)
      bpf_pkg::BK_IDLE: begin
        kind  <= bpf_pkg::job_kind_t'(job[JW-1 -: bpf_pkg::JOB_KIND_W]);
        px[0] <= job[8*CW-1 -: CW];
        py[0] <= job[7*CW-1 -: CW];
        px[1] <= job[6*CW-1 -: CW];
        py[1] <= job[5*CW-1 -: CW];
        px[2] <= job[4*CW-1 -: CW];
        py[2] <= job[3*CW-1 -: CW];
        px[3] <= job[2*CW-1 -: CW];
        py[3] <= job[CW-1 -: CW];
        side  <= 2'd0;
        len   <= '0;
      end
      bpf_pkg::BK_SQ_DX: dsq <= m31x * m31x;
      bpf_pkg::BK_SQ_DY: begin
        sq_v   <= 64'(dsq) + 64'(62'(m31y) * 62'(m31y));
        sq_r   <= '0;
        sq_bit <= 5'd31;
      end
      bpf_pkg::BK_SQRT: begin
        sq_v   <= v_new;
        sq_r   <= r_new;
        sq_bit <= sq_bit - 5'd1;
        if (sq_bit == 5'd0) begin
          len  <= (len_sum > 34'(bpf_pkg::LEN_CAP)) ? bpf_pkg::LEN_CAP : len_sum[24:0];
          side <= side + 2'd1;
        end
      end
      bpf_pkg::BK_CNT_A: begin
        lsq <= 50'(len) * 50'(len);
        ss  <= 16'(s_eff) * 16'(s_eff);
        mm  <= 10'(m_sel) * 10'(m_sel);
      end
      bpf_pkg::BK_CNT_B: kc <= {(19'(ss) << 2) + 19'(ss), 16'd0};
      bpf_pkg::BK_CNT_C: begin
        km    <= 45'(kc) * 45'(mm);
        kn2   <= 52'(kc);
        kstep <= (52'(kc) << 1) + 52'(kc);
        n     <= NW'(1);
      end
      bpf_pkg::BK_CNT_D: target <= (52'(lsq) << 1) + 52'(lsq) + 52'(km);
      bpf_pkg::BK_SEARCH: begin
        if (!(kn2 >= target || n == NW'(MAX_POINTS))) begin
          n     <= n + NW'(1);
          kn2   <= kn2 + kstep;
          kstep <= kstep + (52'(kc) << 1);
        end
      end
      bpf_pkg::BK_START: idx <= NW'(1);
      bpf_pkg::BK_WGT_A: begin
        uu <= UW'(u) * UW'(u);
        ui <= UW'(u) * UW'(idx);
        ii <= UW'(idx) * UW'(idx);
        nn <= UW'(n) * UW'(n);
      end
      bpf_pkg::BK_WGT_B: begin
        if (kind == bpf_pkg::JOB_QUAD) begin
          w[0] <= WW'(uu);
          w[1] <= WW'(ui) << 1;
          w[2] <= WW'(ii);
          w[3] <= '0;
          den  <= WW'(nn);
        end else begin
          w[0] <= WW'(uu) * WW'(u);
          w[1] <= (m_uui << 1) + m_uui;
          w[2] <= (m_uii << 1) + m_uii;
          w[3] <= WW'(ii) * WW'(idx);
          den  <= WW'(nn) * WW'(n);
        end
        accx <= '0;
        accy <= '0;
        j    <= 2'd0;
      end
      bpf_pkg::BK_MAC: begin
        accx <= accx + prx;
        accy <= accy + pry;
        j    <= j + 2'd1;
      end
      bpf_pkg::BK_DIV_PREP: begin
        // Round half up is the floor of (2*num + den) / (2*den).
        negx <= tx[TW-1];
        negy <= ty[TW-1];
        ax   <= tx[TW-1] ? AW'(-tx) + AW'({den, 1'b0}) - AW'(1) : AW'(tx);
        ay   <= ty[TW-1] ? AW'(-ty) + AW'({den, 1'b0}) - AW'(1) : AW'(ty);
        qx   <= '0;
        qy   <= '0;
        dj   <= DJW'(QW - 1);
      end
      bpf_pkg::BK_DIV: begin
        if (ax >= dsh) begin
          ax <= ax - dsh;
          qx <= qx | (QW'(1) << dj);
        end
        if (ay >= dsh) begin
          ay <= ay - dsh;
          qy <= qy | (QW'(1) << dj);
        end
        dj <= dj - DJW'(1);
      end
      bpf_pkg::BK_POINT: begin
        if (o_free) idx <= idx + NW'(1);
      end
      default: ;
    endcase
  end

  // Registered output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && o_free) begin
      o_x    <= push_x;
      o_y    <= push_y;
      o_last <= push_last;
    end
  end

  assign pt.valid   = o_valid;
  assign pt.point_x = o_x;
  assign pt.point_y = o_y;
  assign pt.last    = o_last;

  // The first emitted point of a curve needs a count in range.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == bpf_pkg::BK_START) |-> (n != '0 && 32'(n) <= MAX_POINTS))
    else $error("point count out of range");

  // Inner points are computed only for indexes below the count.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == bpf_pkg::BK_WGT_A) |-> (idx != '0 && idx < n))
    else $error("inner point index out of range");

  // A satisfied count test goes straight to emission.
  a_search_done: assert property (@(posedge clk) disable iff (rst)
    (state == bpf_pkg::BK_SEARCH && kn2 >= target) |=> (state == bpf_pkg::BK_START))
    else $error("count search did not stop");

  // The divider only hands off to the point push.
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == bpf_pkg::BK_DIV) |=> (state == bpf_pkg::BK_DIV || state == bpf_pkg::BK_POINT))
    else $error("divider left early");

endmodule

[tb/bpf_checker.sv]
// Checker for the Bezier path flattener: watches the request, point and
// register channels, predicts polyline points and compares them in order.
// Depends on bpf_pkg and the channel interfaces in bpf_if.sv.
`timescale 1ns / 100ps

module bpf_checker (
  input  logic       clk,
  input  logic       rst,
  bpf_seg_if.sink    seg_mon,
  bpf_pt_if.sink     pt_mon,
  bpf_cfg_if.sink    cfg_mon,
  output int         fail_count,
  output int         pending_points,
  output int         points_seen
);
  localparam int CW = bpf_pkg::COORD_WIDTH_DEF;
  localparam int NMAX = bpf_pkg::MAX_POINTS_DEF;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } poly_point_t;

  poly_point_t expected_points[$];

  logic [4:0] quad_min, cubic_min;
  logic [7:0] seg_len;
  longint cur_x, cur_y, refl_x, refl_y;

  // Add one predicted point at the tail of the queue.
  function automatic void append_point(poly_point_t p);
    expected_points.insert(expected_points.size(), p);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned capped_mag(longint d);
    longint unsigned m;
    m = (d < 0) ? longint'(-d) : longint'(d);
    return (m > 64'h7FFFFFFF) ? 64'h7FFFFFFF : m;
  endfunction

  function automatic longint unsigned side_length(longint x0, longint y0, longint x1,
                                                  longint y1);
    longint unsigned dx, dy;
    dx = capped_mag(x1 - x0);
    dy = capped_mag(y1 - y0);
    return int_sqrt(dx * dx + dy * dy);
  endfunction

  function automatic int point_count(longint unsigned len, longint unsigned minp);
    longint unsigned s, k, target;
    s = (seg_len == 0) ? 1 : seg_len;
    k = 5 * 65536 * s * s;
    if (len > (64'd1 << 24)) len = 64'd1 << 24;
    target = 3 * len * len + k * minp * minp;
    for (int n = 1; n < NMAX; n++)
      if (k * n * n >= target) return n;
    return NMAX;
  endfunction

  // Nearest rounding with ties toward plus infinity; den is positive.
  function automatic longint round_div(longint num, longint den);
    longint t, d2;
    t = 2 * num + den;
    d2 = 2 * den;
    if (t >= 0) return t / d2;
    return -((-t + d2 - 1) / d2);
  endfunction

  function automatic longint bernstein(int order, longint p0, longint p1, longint p2,
                                       longint p3, longint n, longint i);
    longint u;
    u = n - i;
    if (order == 2) return round_div(u*u*p0 + 2*i*u*p1 + i*i*p2, n*n);
    return round_div(u*u*u*p0 + 3*u*u*i*p1 + 3*u*i*i*p2 + i*i*i*p3, n*n*n);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // Turn one accepted segment request into its expected points.
  task automatic flatten_segment(logic [2:0] fn, longint ex, longint ey, longint c1x,
                                 longint c1y, longint c2x, longint c2y);
    longint px[4], py[4];
    longint unsigned len;
    int order, n;
    poly_point_t p;
    if (fn > bpf_pkg::FN_CUBIC) return;
    if (fn == bpf_pkg::FN_MOVE || fn == bpf_pkg::FN_LINE) begin
      p.x = CW'(ex); p.y = CW'(ey); p.last = 1'b1;
      append_point(p);
      cur_x = ex; cur_y = ey; refl_x = ex; refl_y = ey;
      return;
    end
    px[0] = cur_x; py[0] = cur_y;
    if (fn == bpf_pkg::FN_SQUAD || fn == bpf_pkg::FN_SCUBIC) begin
      px[1] = refl_x; py[1] = refl_y;
    end else begin
      px[1] = c1x; py[1] = c1y;
    end
    if (fn == bpf_pkg::FN_SQUAD || fn == bpf_pkg::FN_QUAD) begin
      order = 2;
      px[2] = ex; py[2] = ey; px[3] = 0; py[3] = 0;
    end else begin
      order = 3;
      px[2] = (fn == bpf_pkg::FN_SCUBIC) ? c1x : c2x;
      py[2] = (fn == bpf_pkg::FN_SCUBIC) ? c1y : c2y;
      px[3] = ex; py[3] = ey;
    end
    len = 0;
    for (int k = 0; k < order; k++)
      len += side_length(px[k], py[k], px[k+1], py[k+1]);
    n = point_count(len, (order == 2) ? 64'(quad_min) : 64'(cubic_min));
    p.x = CW'(px[0]); p.y = CW'(py[0]); p.last = 1'b0;
    append_point(p);
    for (int i = 1; i < n; i++) begin
      p.x = CW'(bernstein(order, px[0], px[1], px[2], px[3], n, i));
      p.y = CW'(bernstein(order, py[0], py[1], py[2], py[3], n, i));
      append_point(p);
    end
    p.x = CW'(ex); p.y = CW'(ey); p.last = 1'b1;
    append_point(p);
    refl_x = clamp_coord(2 * ex - px[order-1]);
    refl_y = clamp_coord(2 * ey - py[order-1]);
    cur_x = ex; cur_y = ey;
  endtask

  assign pending_points = expected_points.size();

  // Sample all three channels at the clock edge and update the prediction.
  always @(posedge clk) begin
    poly_point_t want;
    if (rst) begin
      quad_min <= bpf_pkg::QUAD_MIN_RST;
      cubic_min <= bpf_pkg::CUBIC_MIN_RST;
      seg_len <= bpf_pkg::SEG_LEN_RST;
      cur_x = 0; cur_y = 0; refl_x = 0; refl_y = 0;
      expected_points.delete();
      fail_count <= 0;
      points_seen <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        unique case (cfg_mon.index)
          bpf_pkg::REG_QUAD_MIN:  quad_min <= cfg_mon.data[4:0];
          bpf_pkg::REG_CUBIC_MIN: cubic_min <= cfg_mon.data[4:0];
          bpf_pkg::REG_SEG_LEN:   seg_len <= cfg_mon.data;
          default: ;
        endcase
      end
      if (seg_mon.valid && seg_mon.ready)
        flatten_segment(seg_mon.func, seg_mon.end_x, seg_mon.end_y, seg_mon.ctrl1_x,
                        seg_mon.ctrl1_y, seg_mon.ctrl2_x, seg_mon.ctrl2_y);
      if (pt_mon.valid && pt_mon.ready) begin
        points_seen <= points_seen + 1;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time, pt_mon.point_x,
                   pt_mon.point_y, pt_mon.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_points.pop_front();
          if (want.x !== pt_mon.point_x || want.y !== pt_mon.point_y ||
              want.last !== pt_mon.last) begin
            $display("%0t: point mismatch expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $time, want.x, want.y, want.last, pt_mon.point_x, pt_mon.point_y,
                     pt_mon.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/testbench.sv]
// Top of the Bezier path flattener testbench: clock, reset, register writes,
// segment requests and the point sink with random stalls, plus the verdict.
// Depends on bpf_pkg, bpf_if.sv, bpf_checker.sv and the block itself.
`timescale 1ns / 100ps

module testbench;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_SEGMENTS = 240;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count, pending_points, points_seen;
  int cycle_count = 0;
  int segments_sent = 0;
  bit no_idle = 1'b0;

  bpf_seg_if seg ();
  bpf_pt_if  pt ();
  bpf_cfg_if cfg ();

  bezier_path_flattener dut (.clk(clk), .rst(rst), .seg(seg), .pt(pt), .cfg(cfg));

  bpf_checker u_checker (.clk(clk), .rst(rst), .seg_mon(seg), .pt_mon(pt), .cfg_mon(cfg),
                         .fail_count(fail_count), .pending_points(pending_points),
                         .points_seen(points_seen));

  always #10 clk = ~clk;

  // Point sink stalls about a quarter of the time outside the quiet stretch.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) pt.ready <= 1'b0;
    else pt.ready <= no_idle || ($urandom_range(99) >= 24);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run timed out with %0d points outstanding", pending_points);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One register write; the write channel is then left idle before the task returns.
  task automatic write_register(logic [bpf_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
    cfg.index <= idx;
    cfg.data <= value;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop the request, wait until every predicted point has come out, then settle.
  task automatic drain;
    seg.valid <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // The request stays valid after acceptance; the next idle cycle or drain drops it.
  task automatic send_segment(logic [2:0] fn, logic [23:0] ex, logic [23:0] ey,
                              logic [23:0] c1x, logic [23:0] c1y, logic [23:0] c2x,
                              logic [23:0] c2y);
    while (!no_idle && $urandom_range(99) < 24) begin
      seg.valid <= 1'b0;
      @(posedge clk);
    end
    seg.func <= fn;
    seg.end_x <= ex; seg.end_y <= ey;
    seg.ctrl1_x <= c1x; seg.ctrl1_y <= c1y;
    seg.ctrl2_x <= c2x; seg.ctrl2_y <= c2y;
    seg.valid <= 1'b1;
    do @(posedge clk); while (!seg.ready);
    segments_sent++;
  endtask

  // Coordinates mostly near the origin so curves stay short, sometimes full range.
  function automatic logic [23:0] rand_coord();
    unique case ($urandom_range(9))
      0: return 24'($urandom);
      1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(16383)) - 8192);
    endcase
  endfunction

  task automatic random_segment();
    logic [2:0] fn;
    fn = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    send_segment(fn, rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord());
  endtask

  initial begin
    seg.valid = 1'b0; seg.func = bpf_pkg::FN_MOVE;
    seg.end_x = '0; seg.end_y = '0; seg.ctrl1_x = '0; seg.ctrl1_y = '0;
    seg.ctrl2_x = '0; seg.ctrl2_y = '0;
    cfg.valid = 1'b0; cfg.index = bpf_pkg::REG_QUAD_MIN; cfg.data = '0;
    pt.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed segments at reset settings: every kind, extremes, saturation.
    send_segment(bpf_pkg::FN_MOVE, 24'h000100, 24'h000200, '0, '0, '0, '0);
    send_segment(bpf_pkg::FN_LINE, 24'h001000, 24'hFFF000, '0, '0, '0, '0);
    send_segment(bpf_pkg::FN_QUAD, 24'h002000, 24'h002000, 24'h001800, 24'h000000, '0, '0);
    send_segment(bpf_pkg::FN_SQUAD, 24'h000000, 24'h000000, '0, '0, '0, '0);
    send_segment(bpf_pkg::FN_CUBIC, 24'h003000, 24'h001000, 24'h000400, 24'h002000,
                 24'h002800, 24'hFFE000);
    send_segment(bpf_pkg::FN_SCUBIC, 24'hFFF000, 24'h000800, 24'h000000, 24'h001000,
                 '0, '0);
    send_segment(3'd6, 24'h123456, 24'h654321, 24'hABCDEF, '0, '0, '0);
    send_segment(3'd7, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                 24'hFFFFFF);
    send_segment(bpf_pkg::FN_MOVE, 24'h7FFFFF, 24'h7FFFFF, '0, '0, '0, '0);
    send_segment(bpf_pkg::FN_QUAD, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, '0, '0);
    send_segment(bpf_pkg::FN_SQUAD, 24'h800000, 24'h7FFFFF, '0, '0, '0, '0);
    send_segment(bpf_pkg::FN_CUBIC, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000,
                 24'h800000, 24'h7FFFFF);
    send_segment(bpf_pkg::FN_SCUBIC, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
                 '0, '0);
    send_segment(bpf_pkg::FN_LINE, 24'h000000, 24'h000000, '0, '0, '0, '0);
    send_segment(bpf_pkg::FN_CUBIC, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
                 24'h000000, 24'h000000);
    drain();

    // Smallest counts and the zero segment length quirk.
    write_register(bpf_pkg::REG_QUAD_MIN, 8'd1);
    write_register(bpf_pkg::REG_CUBIC_MIN, 8'd1);
    write_register(bpf_pkg::REG_SEG_LEN, 8'd0);
    send_segment(bpf_pkg::FN_QUAD, 24'h000400, 24'h000000, 24'h000200, 24'h000200, '0, '0);
    send_segment(bpf_pkg::FN_CUBIC, 24'h000000, 24'h000400, 24'h000100, 24'h000100,
                 24'h000300, 24'h000300);
    drain();

    // Random phases under several register settings, extremes included.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_register(bpf_pkg::REG_QUAD_MIN, 8'd31);
          write_register(bpf_pkg::REG_CUBIC_MIN, 8'd31);
          write_register(bpf_pkg::REG_SEG_LEN, 8'd255);
        end
        1: begin
          write_register(bpf_pkg::REG_QUAD_MIN, 8'($urandom_range(31, 1)));
          write_register(bpf_pkg::REG_CUBIC_MIN, 8'($urandom_range(31, 1)));
          write_register(bpf_pkg::REG_SEG_LEN, 8'd1);
        end
        2: begin
          write_register(bpf_pkg::REG_QUAD_MIN, 8'($urandom_range(8, 1)));
          write_register(bpf_pkg::REG_CUBIC_MIN, 8'($urandom_range(12, 1)));
          write_register(bpf_pkg::REG_SEG_LEN, 8'($urandom_range(255, 1)));
        end
        default: begin
          write_register(bpf_pkg::REG_QUAD_MIN, 8'd5);
          write_register(bpf_pkg::REG_CUBIC_MIN, 8'd10);
          write_register(bpf_pkg::REG_SEG_LEN, 8'd30);
        end
      endcase
      no_idle = (phase == 2);
      for (int i = 0; i < RANDOM_SEGMENTS / 4; i++) random_segment();
      drain();
    end
    no_idle = 1'b0;

    $display("Flattened %0d segment requests into %0d points over %0d register settings.",
             segments_sent, points_seen, 6);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
